// ----- rtl/tce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_pkg
// shared types, constants and codes of the text console engine
// ----------------------------------------------------------------------------
package tce_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;   // power of two
  localparam int CELLS      = COLUMNS * ROWS;
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELLS);

  // field widths
  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int LOC_W   = 11;
  localparam int CELL_W  = 16;
  localparam int ATTR_W  = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef enum logic [1:0] {
    SW_NONE,
    SW_INIT,
    SW_CLEAR,
    SW_SCROLL
  } sweep_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [LOC_W-1:0]  cursor_location;
    logic [CELL_W-1:0] cell_value;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic   accept;
    logic   exec;
    logic   respond;
    sweep_e sweep;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_put;
    logic is_clear;
    logic need_scroll;
    logic sweep_last;
  } dp_sts_t;

endpackage

// ----- rtl/text_console_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_engine_core
// 80x25 text console: cell memory, cursor control, scroll and clear
// ----------------------------------------------------------------------------
// an item is taken at a clock edge with start high and busy low; its one
// result shows on result_o for exactly one cycle with result_valid_o high,
// and the receiver cannot stall it, so capture it when the strobe is seen.
// put of a printing or control byte, read and the unused command pass
// through the execute state, then the result strobe, during which the next
// item can already be accepted. clear and any put that runs past the bottom
// row hold busy through a sweep in which the single write port of the cell
// memory walks every cell once (scroll copies one cell per cycle through a
// registered write stage). after reset busy stays high while the memory is
// filled with blanks; attribute writes are taken meanwhile.
// ----------------------------------------------------------------------------
module text_console_engine_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item channel
  input  logic              start,
  output logic              busy,
  input  tce_pkg::item_t    item_i,
  // result strobe
  output logic              result_valid_o,
  output tce_pkg::result_t  result_o,
  // attribute register write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i
);
  import tce_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  // attribute register never pushes back
  assign cfg_ready_o = 1'b1;

  // sequencer: reset fill, execute, clear and scroll sweeps
  tce_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (dp_sts),
    .cmd_o  (ctl_cmd)
  );

  // cell memory, cursor and result register
  tce_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .item_i         (item_i),
    .cmd_i          (ctl_cmd),
    .sts_o          (dp_sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ----- rtl/tce_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_ctrl
// sequencer for item execution and screen sweeps
// ----------------------------------------------------------------------------
module tce_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tce_pkg::dp_sts_t sts_i,
  output tce_pkg::ctl_cmd_t cmd_o
);
  import tce_pkg::*;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_CLEAR  = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.accept  = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.respond = 1'b0;
    cmd_o.sweep   = SW_NONE;
    busy          = 1'b1;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep = SW_INIT;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.is_clear) begin
          state_d = ST_CLEAR;
        end else if (sts_i.is_put && sts_i.need_scroll) begin
          state_d = ST_SCROLL;
        end else begin
          cmd_o.respond = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_CLEAR, ST_SCROLL: begin
        cmd_o.sweep = (state_q == ST_CLEAR) ? SW_CLEAR : SW_SCROLL;
        if (sts_i.sweep_last) begin
          cmd_o.respond = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/tce_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_datapath
// cell memory, cursor, attribute register, sweep counter and result register
// ----------------------------------------------------------------------------
module tce_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_data_i,
  input  tce_pkg::item_t     item_i,
  input  tce_pkg::ctl_cmd_t  cmd_i,
  output tce_pkg::dp_sts_t   sts_o,
  output logic               result_valid_o,
  output tce_pkg::result_t   result_o
);
  import tce_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];

  logic [ATTR_W-1:0]  attr_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [CMD_W-1:0]   cmd_q;
  logic [CHAR_W-1:0]  char_q;
  logic               idx_ok_q;
  logic [ADDR_W-1:0]  ptr_q;
  logic               sweeping;
  logic               sweep_last;

  // write stage, registered: it acts in the cycle after the issuing cycle
  logic               wr_en_q, wr_en_d;
  logic [ADDR_W-1:0]  wr_addr_q, wr_addr_d;
  logic               wr_copy_q, wr_copy_d;
  logic [CELL_W-1:0]  wr_data_q, wr_data_d;
  logic [CELL_W-1:0]  wdata;

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [CELL_W-1:0]  rd_data_q;

  logic               res_valid_q;
  result_t            res_q, res_d;

  logic [COL_W:0]     col_x;
  logic [ROW_W:0]     row_x;
  logic               put_wr;
  logic               need_scroll;
  logic [ADDR_W-1:0]  put_loc;
  logic [CELL_W-1:0]  blank;
  logic               copy_phase;

  assign blank      = {attr_q, CH_SPACE};
  assign sweeping   = (cmd_i.sweep != SW_NONE);
  assign sweep_last = (ptr_q == ADDR_W'(CELLS - 1));
  assign copy_phase = (ptr_q < ADDR_W'(COPY_CELLS));
  assign put_loc    = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);

  // cursor motion for a put
  always_comb begin
    col_x  = {1'b0, col_q};
    row_x  = {1'b0, row_q};
    put_wr = 1'b0;
    unique case (char_q)
      CH_BS: begin
        if (col_q != '0) col_x = {1'b0, col_q} - 1'b1;
      end
      CH_TAB: begin
        // next tab stop; tab width is a power of two
        col_x = ({1'b0, col_q} & ~(COL_W+1)'(TAB_WIDTH - 1)) + (COL_W+1)'(TAB_WIDTH);
      end
      CH_CR: begin
        col_x = '0;
      end
      CH_LF: begin
        col_x = '0;
        row_x = {1'b0, row_q} + 1'b1;
      end
      default: begin
        if (char_q >= CH_SPACE && char_q <= CH_LAST) begin
          put_wr = 1'b1;
          col_x  = {1'b0, col_q} + 1'b1;
        end
      end
    endcase
    if (col_x >= (COL_W+1)'(COLUMNS)) begin
      col_x = '0;
      row_x = row_x + 1'b1;
    end
    need_scroll = (row_x >= (ROW_W+1)'(ROWS));
    if (need_scroll) row_x = (ROW_W+1)'(ROWS - 1);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.exec) begin
      if (cmd_q == CMD_PUT) begin
        col_d = col_x[COL_W-1:0];
        row_d = row_x[ROW_W-1:0];
      end else if (cmd_q == CMD_CLEAR) begin
        col_d = '0;
        row_d = '0;
      end
    end
  end

  // write stage and read port selection
  always_comb begin
    wr_en_d   = 1'b0;
    wr_addr_d = ptr_q;
    wr_copy_d = 1'b0;
    wr_data_d = blank;
    rd_en     = 1'b0;
    rd_addr   = item_i.cell_index[ADDR_W-1:0];
    if (cmd_i.exec && cmd_q == CMD_PUT && put_wr) begin
      wr_en_d   = 1'b1;
      wr_addr_d = put_loc;
      wr_data_d = {attr_q, char_q};
    end
    if (cmd_i.accept) begin
      rd_en = (item_i.cell_index < INDEX_W'(CELLS));
    end
    unique case (cmd_i.sweep)
      SW_NONE: begin
      end
      SW_INIT: begin
        wr_en_d   = 1'b1;
        wr_data_d = {ATTR_RESET, CH_SPACE};
      end
      SW_CLEAR: begin
        wr_en_d = 1'b1;
      end
      SW_SCROLL: begin
        wr_en_d   = 1'b1;
        wr_copy_d = copy_phase;
        rd_en     = copy_phase;
        rd_addr   = ptr_q + ADDR_W'(COLUMNS);
      end
      default: begin
      end
    endcase
  end

  assign wdata = wr_copy_q ? rd_data_q : wr_data_q;

  // cell memory, read with write-through bypass
  always_ff @(posedge clk_i) begin
    if (wr_en_q) mem[wr_addr_q] <= wdata;
    if (rd_en) begin
      if (wr_en_q && wr_addr_q == rd_addr) begin
        rd_data_q <= wdata;
      end else begin
        rd_data_q <= mem[rd_addr];
      end
    end
  end

  always_comb begin
    res_d.cursor_column   = col_d;
    res_d.cursor_row      = row_d;
    res_d.cursor_location = LOC_W'(row_d) * LOC_W'(COLUMNS) + LOC_W'(col_d);
    res_d.cell_value      = (cmd_q == CMD_READ && idx_ok_q) ? rd_data_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= ATTR_RESET;
      col_q       <= '0;
      row_q       <= '0;
      ptr_q       <= '0;
      wr_en_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) attr_q <= cfg_data_i;
      col_q       <= col_d;
      row_q       <= row_d;
      wr_en_q     <= wr_en_d;
      res_valid_q <= cmd_i.respond;
      if (sweeping) begin
        ptr_q <= sweep_last ? '0 : ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    wr_copy_q <= wr_copy_d;
    wr_data_q <= wr_data_d;
    if (cmd_i.accept) begin
      cmd_q    <= item_i.command;
      char_q   <= item_i.char_code;
      idx_ok_q <= (item_i.cell_index < INDEX_W'(CELLS));
    end
    if (cmd_i.respond) res_q <= res_d;
  end

  assign sts_o.is_put      = (cmd_q == CMD_PUT);
  assign sts_o.is_clear    = (cmd_q == CMD_CLEAR);
  assign sts_o.need_scroll = need_scroll;
  assign sts_o.sweep_last  = sweep_last;

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ----- tb/text_console_engine_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_engine_core_test
// self-checking bench for the 80x25 text console: a local screen and cursor
// model predicts every result, a clocked driver feeds items from a backlog
// and a clocked monitor compares each result strobe field by field
// ----------------------------------------------------------------------------
module text_console_engine_core_test;
  import tce_pkg::*;

  // the one command code the package leaves unnamed: does nothing
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  // worst case per item: a full sweep, the longest gap and a few spare cycles
  localparam int SWEEP_CYCLES = CELLS + 1;
  localparam int RUN_LIMIT    = CELLS + 1500 * (SWEEP_CYCLES + 20) * 3;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 240;

  logic    clk_i          = 1'b0;
  logic    rst_ni         = 1'b0;
  logic    start          = 1'b0;
  logic    busy;
  item_t   item_i         = '0;
  logic    result_valid_o;
  result_t result_o;
  logic    cfg_valid_i    = 1'b0;
  logic    cfg_ready_o;
  logic [ATTR_W-1:0] cfg_data_i = '0;

  // local copy of the console: cells, cursor and attribute
  logic [CELL_W-1:0] screen_model [CELLS];
  int                cursor_col;
  int                cursor_line;
  logic [ATTR_W-1:0] attr_now;

  item_t   cmd_backlog[$];        // items waiting for the driver
  result_t expected_reports[$];   // predicted results, oldest first
  int      reports_owed   = 0;    // items queued whose result has not shown up
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  int      gap_left       = 0;
  bit      idle_on        = 1'b1;

  text_console_engine_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // console model
  // ---------------------------------------------------------------------------

  // blank the cell range with the current attribute
  function automatic void blank_cells(int first, int last);
    for (int i = first; i < last; i++) begin
      screen_model[i] = {attr_now, CH_SPACE};
    end
  endfunction

  // interpret one byte of a put: cursor moves, printing bytes land in memory
  function automatic void put_char(logic [CHAR_W-1:0] code);
    int loc;
    if (code == CH_BS) begin
      if (cursor_col > 0) cursor_col--;  // column 0 stays put
    end else if (code == CH_TAB) begin
      cursor_col = cursor_col + TAB_WIDTH - (cursor_col % TAB_WIDTH);
    end else if (code == CH_CR) begin
      cursor_col = 0;
    end else if (code == CH_LF) begin
      cursor_col = 0;
      cursor_line++;
    end else if (code >= CH_SPACE && code <= CH_LAST) begin
      loc = cursor_line * COLUMNS + cursor_col;
      if (loc < CELLS) screen_model[loc] = {attr_now, code};
      cursor_col++;
    end
    // anything else (other controls, bytes with the top bit set) is ignored
    if (cursor_col >= COLUMNS) begin
      // line wrap, also reached by a tab past the last column
      cursor_col = 0;
      cursor_line++;
    end
    if (cursor_line >= ROWS) begin
      // scroll up one line and blank the bottom row
      for (int i = 0; i < COPY_CELLS; i++) begin
        screen_model[i] = screen_model[i + COLUMNS];
      end
      blank_cells(COPY_CELLS, CELLS);
      cursor_line = ROWS - 1;
    end
  endfunction

  // apply one accepted item and return the result it must produce
  function automatic result_t console_apply(item_t it);
    result_t           rep;
    logic [CELL_W-1:0] cell_val;
    cell_val = '0;
    unique case (it.command)
      CMD_PUT: begin
        put_char(it.char_code);
      end
      CMD_CLEAR: begin
        blank_cells(0, CELLS);
        cursor_col  = 0;
        cursor_line = 0;
      end
      CMD_READ: begin
        // out-of-range addresses read as zero
        if (it.cell_index < CELLS) cell_val = screen_model[it.cell_index];
      end
      default: begin
        // unused command: only the cursor is reported
      end
    endcase
    rep.cursor_column   = COL_W'(cursor_col);
    rep.cursor_row      = ROW_W'(cursor_line);
    rep.cursor_location = LOC_W'(cursor_line * COLUMNS + cursor_col);
    rep.cell_value      = cell_val;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic item_t make_item(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] code,
                                      logic [INDEX_W-1:0] idx);
    item_t it;
    it.command    = cmd;
    it.char_code  = code;
    it.cell_index = idx;
    return it;
  endfunction

  task automatic queue_item(item_t it);
    reports_owed++;
    cmd_backlog.push_back(it);
  endtask

  // mostly text with line breaks and cursor moves, plus reads; clears are
  // rare so the screen fills up and scrolls often
  function automatic item_t random_item();
    item_t it;
    int    roll;
    int    pick;
    it.command    = CMD_PUT;
    it.char_code  = CHAR_W'($urandom);
    it.cell_index = INDEX_W'($urandom);
    roll = $urandom_range(0, 999);
    pick = $urandom_range(0, 99);
    if (roll >= 720 && roll < 880) begin
      it.command = CMD_READ;
      if (pick < 90) it.cell_index = INDEX_W'($urandom_range(0, CELLS - 1));
      else           it.cell_index = INDEX_W'($urandom_range(CELLS, 2 ** INDEX_W - 1));
    end else if (roll >= 880 && roll < 883) begin
      it.command = CMD_CLEAR;
    end else if (roll >= 883 && roll < 900) begin
      it.command = CMD_NOP;
    end else begin
      if (pick < 60)      it.char_code = CHAR_W'($urandom_range(CH_SPACE, CH_LAST));
      else if (pick < 75) it.char_code = CH_LF;
      else if (pick < 79) it.char_code = CH_CR;
      else if (pick < 86) it.char_code = CH_TAB;
      else if (pick < 93) it.char_code = CH_BS;
      // else keep the raw random byte: control codes and high bytes
    end
    return it;
  endfunction

  // hold the sender until every result is in and the engine is idle
  task automatic settle();
    @(posedge clk_i);
    while (reports_owed != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    attr_now = value;
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents backlog items, predicts at acceptance, random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic accepted;
    if (!rst_ni) begin
      start    <= 1'b0;
      item_i   <= '0;
      gap_left = 0;
    end else begin
      accepted = start && !busy;
      if (accepted) expected_reports.push_back(console_apply(item_i));
      if (!(start && !accepted)) begin
        // free to present the next item, or to idle
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_backlog.size() > 0 && idle_on && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 12) - 1;
          start <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          item_i <= cmd_backlog.pop_front();
          start  <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobe is matched against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    result_t want;
    if (rst_ni && result_valid_o) begin
      reports_owed--;
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result with no item pending: %p", result_o);
      end else begin
        want = expected_reports.pop_front();
        if (result_o.cursor_column !== want.cursor_column ||
            result_o.cursor_row !== want.cursor_row ||
            result_o.cursor_location !== want.cursor_location ||
            result_o.cell_value !== want.cell_value) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected col %0d row %0d loc %0d cell %h", want.cursor_column,
                     want.cursor_row, want.cursor_location, want.cell_value);
            $display("          actual   col %0d row %0d loc %0d cell %h",
                     result_o.cursor_column, result_o.cursor_row,
                     result_o.cursor_location, result_o.cell_value);
          end
        end
      end
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [ATTR_W-1:0] phase_attr [PHASES];
    phase_attr[0] = 8'h00;
    phase_attr[1] = 8'hFF;
    phase_attr[2] = ATTR_W'($urandom_range(1, 254));
    phase_attr[3] = 8'h80;
    phase_attr[4] = 8'h7F;
    phase_attr[5] = ATTR_W'($urandom_range(1, 254));

    // model starts as after reset: blanks with the reset attribute, cursor home
    attr_now    = ATTR_RESET;
    cursor_col  = 0;
    cursor_line = 0;
    blank_cells(0, CELLS);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reads at the ends of the address range and beyond it
    queue_item(make_item(CMD_READ, 8'h00, 11'd0));
    queue_item(make_item(CMD_READ, 8'hFF, 11'(CELLS - 1)));
    queue_item(make_item(CMD_READ, 8'h55, 11'h7FF));
    // printing bytes at both ends of the printable range
    queue_item(make_item(CMD_PUT, 8'h41, 11'h7FF));
    queue_item(make_item(CMD_PUT, CH_LAST, 11'h2AA));
    queue_item(make_item(CMD_PUT, CH_SPACE, 11'h555));
    // ignored bytes: null, top-bit bytes
    queue_item(make_item(CMD_PUT, 8'h00, 11'd0));
    queue_item(make_item(CMD_PUT, 8'h80, 11'd0));
    queue_item(make_item(CMD_PUT, 8'hFF, 11'd0));
    // carriage return, then backspace in column 0
    queue_item(make_item(CMD_PUT, CH_CR, 11'd0));
    queue_item(make_item(CMD_PUT, CH_BS, 11'd0));
    // ten tabs: the last one runs past the final column and wraps
    repeat (10) queue_item(make_item(CMD_PUT, CH_TAB, 11'd0));
    queue_item(make_item(CMD_PUT, CH_LF, 11'd0));
    queue_item(make_item(CMD_NOP, 8'hFF, 11'h7FF));
    queue_item(make_item(CMD_READ, 8'h00, 11'd1));
    queue_item(make_item(CMD_CLEAR, 8'hFF, 11'h7FF));
    queue_item(make_item(CMD_READ, 8'h00, 11'd0));
    settle();

    // random phases, each under its own attribute; the last one runs flat out
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) idle_on = 1'b0;
      write_attribute(phase_attr[p]);
      repeat (PHASE_ITEMS) queue_item(random_item());
      settle();
    end

    // room for a late sweep or a stray strobe
    repeat (SWEEP_CYCLES + 10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
